// ===== rtl/tfj_pkg.sv =====
// ----------------------------------------------------------------------------
// tfj_pkg
// Shared constants and controller/datapath command and status types for the
// text justification core.
// ----------------------------------------------------------------------------
package tfj_pkg;

  // default buffer depth (MAX_WIDTH) and upper bound for the line width
  localparam int MaxWidth = 32;

  // field widths fixed by the interface
  localparam int CharW = 8;
  localparam int CfgW  = 6;

  // space character and width register reset value
  localparam logic [CharW-1:0] SpaceChar  = 8'd32;
  localparam logic [CfgW-1:0]  WidthReset = 6'd16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;        // input item accepted
    logic decide;      // latch word length, restart word buffer
    logic start_line;  // word opens a new line
    logic append;      // word joins the held line after a separator
    logic copy;        // one step of the word-to-line copy
    logic prep;        // set up line emission and start the divider
    logic prep_full;   // emission is fully justified
    logic emit;        // produce one output character
    logic clear_line;  // drop the held line after the text end
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_end;      // current input item ends a word
    logic text_end;    // latched text end mark
    logic line_empty;  // no word held in the line
    logic fits;        // latched word fits after the held line
    logic copy_done;   // last copy step in progress
    logic div_done;    // gap spacing quotient ready
    logic out_free;    // output register can take a character
    logic emit_last;   // next character closes the line
    logic full;        // current emission is fully justified
  } sts_t;

endpackage

// ===== rtl/text_full_justify_core.sv =====
// ----------------------------------------------------------------------------
// text_full_justify_core
// Greedy full text justification of a character stream into fixed-width
// lines.
// ----------------------------------------------------------------------------
// Characters of words come in one item at a time, marked at word end and text
// end; out come lines of exactly line_width characters, fully justified, with
// the last line of the text and single-word lines left justified and padded.
// An item that does not end a word is simply taken. An item that ends a word
// is then placed through the decide, place and copy states, since the word is
// copied into the line buffer one character per cycle over a single write
// port. When a line goes out, the serial gap divider runs first, and then the
// output characters, read from the line buffer, go out one per cycle while
// the output side is ready. No item is taken while a line is being placed or
// emitted.
// Width changes must be made only while the block is idle.
// ----------------------------------------------------------------------------
module text_full_justify_core #(
  parameter int MAX_WIDTH = tfj_pkg::MaxWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tfj_pkg::CfgW-1:0]  cfg_line_width_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tfj_pkg::CharW-1:0] char_in_i,
  input  logic                      word_end_i,
  input  logic                      text_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tfj_pkg::CharW-1:0] char_out_o,
  output logic                      line_end_o,
  output logic                      run_last_o
);

  tfj_pkg::cmd_t cmd;
  tfj_pkg::sts_t sts;

  // sequencing
  tfj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // buffers, counters and output register
  tfj_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_line_width_i (cfg_line_width_i),
    .char_in_i        (char_in_i),
    .word_end_i       (word_end_i),
    .text_end_i       (text_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .char_out_o       (char_out_o),
    .line_end_o       (line_end_o),
    .run_last_o       (run_last_o)
  );

endmodule

// ===== rtl/tfj_div.sv =====
// ----------------------------------------------------------------------------
// tfj_div
// Restoring divider, one quotient bit per cycle, for the gap spacing of a
// fully justified line.
// ----------------------------------------------------------------------------
module tfj_div #(
  parameter int W = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o,
  output logic         done_o
);

  localparam int SW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q;
  logic [SW-1:0] step_q;
  logic          busy_q;
  logic          done_q;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic [W:0]    quo_sh;
  logic          ge;

  // one restoring step
  always_comb begin
    trial  = {rem_q, quo_q[W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    rem_d  = ge ? diff[W-1:0] : trial[W-1:0];
    quo_sh = {quo_q, ge};
    quo_d  = quo_sh[W-1:0];
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + SW'(1);
      if (step_q == SW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== rtl/tfj_datapath.sv =====
// ----------------------------------------------------------------------------
// tfj_datapath
// Word and line buffers, width register, copy and emission counters, gap
// divider and the output register.
// ----------------------------------------------------------------------------
module tfj_datapath #(
  parameter int MAX_WIDTH = tfj_pkg::MaxWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tfj_pkg::cmd_t              cmd_i,
  output tfj_pkg::sts_t              sts_o,
  input  logic                       cfg_we_i,
  input  logic [tfj_pkg::CfgW-1:0]   cfg_line_width_i,
  input  logic [tfj_pkg::CharW-1:0]  char_in_i,
  input  logic                       word_end_i,
  input  logic                       text_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tfj_pkg::CharW-1:0]  char_out_o,
  output logic                       line_end_o,
  output logic                       run_last_o
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int SPW = CW + 1;
  localparam int FW  = CW + 2;

  logic [tfj_pkg::CharW-1:0] word_store [MAX_WIDTH];
  logic [tfj_pkg::CharW-1:0] line_store [MAX_WIDTH];

  logic [tfj_pkg::CfgW-1:0]  cfg_q;
  logic [CW-1:0]             w_c;
  logic [CW-1:0]             word_fill_q;
  logic [CW-1:0]             wl_q, wl_c;
  logic [CW-1:0]             line_fill_q;
  logic [CW-1:0]             word_total_q;
  logic [CW-1:0]             base_q;
  logic [CW-1:0]             k_q;
  logic [CW-1:0]             wr_pos;
  logic [MAX_WIDTH-1:0]      gap_q;
  logic                      tend_q;
  logic                      full_q;
  logic                      full_c;
  logic [tfj_pkg::CharW-1:0] wrd_q;
  logic [tfj_pkg::CharW-1:0] rd_q;

  logic [CW-1:0]             i_q, i_d;
  logic [CW-1:0]             cnt_q;
  logic [CW-1:0]             g_q, g_d;
  logic [CW-1:0]             sp_q, sp_d;
  logic [CW-1:0]             pad_c, gaps_c;
  logic [CW-1:0]             quo, rmd, digit, remain;
  logic [SPW-1:0]            sp_new;
  logic                      div_done;
  logic                      from_line, is_gap, emit_space;
  logic                      emit_last;
  logic [tfj_pkg::CharW-1:0] emit_char;

  logic                      out_valid_q;
  logic [tfj_pkg::CharW-1:0] char_q;
  logic                      line_end_q;
  logic                      run_last_q;
  logic                      out_free;

  // effective width: zero acts as one, large values clamp
  always_comb begin
    if (cfg_q == '0) begin
      w_c = CW'(1);
    end else if (32'(cfg_q) > 32'(MAX_WIDTH)) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(cfg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tfj_pkg::WidthReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_line_width_i;
    end
  end

  // word length clipped to the width
  assign wl_c   = (word_fill_q < w_c) ? word_fill_q : w_c;
  assign wr_pos = base_q + k_q - CW'(1);

  // word and line bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_fill_q  <= '0;
      wl_q         <= '0;
      line_fill_q  <= '0;
      word_total_q <= '0;
      base_q       <= '0;
      k_q          <= '0;
      gap_q        <= '0;
      tend_q       <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        tend_q <= text_end_i;
        if (word_fill_q < w_c) begin
          word_fill_q <= word_fill_q + CW'(1);
        end
      end
      if (cmd_i.decide) begin
        wl_q        <= wl_c;
        word_fill_q <= '0;
      end
      if (cmd_i.start_line) begin
        line_fill_q  <= wl_q;
        word_total_q <= CW'(1);
        gap_q        <= '0;
        base_q       <= '0;
        k_q          <= '0;
      end
      if (cmd_i.append) begin
        gap_q[line_fill_q[AW-1:0]] <= 1'b1;
        base_q       <= line_fill_q + CW'(1);
        line_fill_q  <= line_fill_q + CW'(1) + wl_q;
        word_total_q <= word_total_q + CW'(1);
        k_q          <= '0;
      end
      if (cmd_i.copy) begin
        k_q <= k_q + CW'(1);
      end
      if (cmd_i.clear_line) begin
        line_fill_q  <= '0;
        word_total_q <= '0;
        gap_q        <= '0;
      end
    end
  end

  // word buffer: written on input, read during the copy
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (word_fill_q < w_c)) begin
      word_store[word_fill_q[AW-1:0]] <= char_in_i;
    end
    wrd_q <= word_store[k_q[AW-1:0]];
  end

  // line buffer: written one step behind the word read, read during emission
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy && (k_q != '0)) begin
      line_store[wr_pos[AW-1:0]] <= wrd_q;
    end
    rd_q <= line_store[i_d[AW-1:0]];
  end

  // gap spacing: spare columns over the gaps, mode taken from the command
  // while the divider is being started
  assign full_c = cmd_i.prep ? cmd_i.prep_full : full_q;
  assign pad_c  = (line_fill_q < w_c) ? (w_c - line_fill_q) : '0;
  assign gaps_c = (full_c && (word_total_q > CW'(1))) ? (word_total_q - CW'(1)) : '0;

  tfj_div #(
    .W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.prep),
    .dividend_i (pad_c),
    .divisor_i  (gaps_c),
    .quo_o      (quo),
    .rem_o      (rmd),
    .done_o     (div_done)
  );

  assign digit  = (gaps_c != '0) ? quo : '0;
  assign remain = (gaps_c != '0) ? rmd : '0;

  // next output character
  always_comb begin
    from_line  = (i_q < line_fill_q);
    is_gap     = from_line && gap_q[i_q[AW-1:0]];
    emit_space = (sp_q != '0) || !from_line || is_gap;
    emit_char  = emit_space ? tfj_pkg::SpaceChar : rd_q;
    sp_new     = SPW'(1) + SPW'(digit) + SPW'(g_q < remain);
    emit_last  = ((SPW'(cnt_q) + SPW'(1)) == SPW'(w_c));

    i_d  = i_q;
    g_d  = g_q;
    sp_d = sp_q;
    if (cmd_i.prep) begin
      i_d  = '0;
      g_d  = '0;
      sp_d = '0;
    end else if (cmd_i.emit) begin
      if (sp_q != '0) begin
        sp_d = sp_q - CW'(1);
      end else if (from_line) begin
        i_d = i_q + CW'(1);
        if (is_gap) begin
          sp_d = CW'(sp_new - SPW'(1));
          g_d  = g_q + CW'(1);
        end
      end
    end
  end

  // emission counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      g_q    <= '0;
      sp_q   <= '0;
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else begin
      i_q  <= i_d;
      g_q  <= g_d;
      sp_q <= sp_d;
      if (cmd_i.prep) begin
        cnt_q  <= '0;
        full_q <= cmd_i.prep_full;
      end else if (cmd_i.emit) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q     <= emit_char;
      line_end_q <= emit_last;
      run_last_q <= emit_last && (!full_q || !tend_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign line_end_o  = line_end_q;
  assign run_last_o  = run_last_q;

  // status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.in_end     = word_end_i || text_end_i;
    sts_o.text_end   = tend_q;
    sts_o.line_empty = (word_total_q == '0);
    sts_o.fits       = (FW'(line_fill_q) + FW'(1) + FW'(wl_q)) <= FW'(w_c);
    sts_o.copy_done  = (k_q == wl_q);
    sts_o.div_done   = div_done;
    sts_o.out_free   = out_free;
    sts_o.emit_last  = emit_last;
    sts_o.full       = full_q;
  end

  // an empty line holds no characters
  a_empty_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_total_q == '0) |-> (line_fill_q == '0))
    else $error("line holds characters but no word");

  // held line never outgrows the buffer
  a_line_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_fill_q <= CW'(MAX_WIDTH))
    else $error("line fill beyond buffer depth");

  // a character is only produced into a free output register
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("output overwritten before it was taken");

  // the last result of an item always closes a line
  a_last_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && run_last_q) |-> line_end_q)
    else $error("run end without line end");

endmodule

// ===== rtl/tfj_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfj_ctrl
// Controller state machine: input acceptance, word placement, buffer copy,
// divider wait and character emission.
// ----------------------------------------------------------------------------
module tfj_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tfj_pkg::sts_t sts_i,
  output tfj_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.in_end) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_PLACE;
      end
      S_PLACE: begin
        if (sts_i.line_empty) begin
          cmd_o.start_line = 1'b1;
          state_d          = S_COPY;
        end else if (sts_i.fits) begin
          cmd_o.append = 1'b1;
          state_d      = S_COPY;
        end else begin
          cmd_o.prep      = 1'b1;
          cmd_o.prep_full = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_done) begin
          if (sts_i.text_end) begin
            cmd_o.prep = 1'b1;
            state_d    = S_DIV;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            if (sts_i.full) begin
              cmd_o.start_line = 1'b1;
              state_d          = S_COPY;
            end else begin
              cmd_o.clear_line = 1'b1;
              state_d          = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== dv/text_full_justify_core_tb.sv =====
// ----------------------------------------------------------------------------
// text_full_justify_core_tb
// Self-checking testbench for the text justification core. Words are streamed
// in one character per item, under several line widths and idle patterns.
// A scoreboard class re-justifies the stream on its own and compares every
// output character, with its line-end and run-last marks, in order.
// ----------------------------------------------------------------------------
module text_full_justify_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one output character with its marks
  typedef struct packed {
    logic [tfj_pkg::CharW-1:0] char_out;
    logic                      line_end;
    logic                      run_last;
  } just_char_t;

  // greedy justifier and queue of characters still owed by the block
  class line_justify_sb;
    logic [tfj_pkg::CfgW-1:0]     width_reg;
    logic [tfj_pkg::CharW-1:0]    line_buf[tfj_pkg::MaxWidth];
    logic [tfj_pkg::CharW-1:0]    word_buf[tfj_pkg::MaxWidth];
    logic [tfj_pkg::MaxWidth-1:0] gap_bits;
    int unsigned                  line_fill;
    int unsigned                  word_count;
    int unsigned                  word_fill;
    just_char_t                   pending[$];
    int unsigned                  faults;

    function new();
      width_reg  = tfj_pkg::WidthReset;
      gap_bits   = '0;
      line_fill  = 0;
      word_count = 0;
      word_fill  = 0;
      faults     = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > tfj_pkg::MaxWidth) return tfj_pkg::MaxWidth;
      return width_reg;
    endfunction

    function void set_width(logic [tfj_pkg::CfgW-1:0] value);
      width_reg = value;
    endfunction

    // append one expected character, marks cleared
    function void queue_char(logic [tfj_pkg::CharW-1:0] ch);
      just_char_t c;
      c       = '{char_out: ch, line_end: 1'b0, run_last: 1'b0};
      pending = {pending, c};
    endfunction

    // finished word becomes the first word of a fresh line
    function void open_line(int unsigned wl);
      for (int unsigned k = 0; k < wl; k++) line_buf[k] = word_buf[k];
      line_fill  = wl;
      word_count = 1;
      gap_bits   = '0;
    endfunction

    // queue one line of exactly w characters
    function void flush_line(bit full, int unsigned w);
      int unsigned pad, gaps, step, extra, cnt, g, sp;
      pad   = (line_fill < w) ? w - line_fill : 0;
      gaps  = (full && word_count > 1) ? word_count - 1 : 0;
      step  = gaps ? pad / gaps : 0;
      extra = gaps ? pad % gaps : 0;
      cnt   = 0;
      g     = 0;
      for (int unsigned i = 0; i < line_fill && i < tfj_pkg::MaxWidth && cnt < w; i++) begin
        if (gap_bits[i]) begin
          // leftmost gaps take the leftover spaces
          sp = 1;
          if (gaps) sp += step + ((g < extra) ? 1 : 0);
          g++;
          for (int unsigned k = 0; k < sp && cnt < w; k++) begin
            queue_char(tfj_pkg::SpaceChar);
            cnt++;
          end
        end else begin
          queue_char(line_buf[i]);
          cnt++;
        end
      end
      // right padding
      while (cnt < w) begin
        queue_char(tfj_pkg::SpaceChar);
        cnt++;
      end
      pending[pending.size()-1].line_end = 1'b1;
    endfunction

    // accepted input item
    function void take_char(logic [tfj_pkg::CharW-1:0] ch, logic we, logic te);
      int unsigned w, wl, mark;
      w    = eff_width();
      mark = pending.size();
      if (word_fill < w) begin
        word_buf[word_fill] = ch;
        word_fill++;
      end
      if (!we && !te) return;
      wl        = (word_fill < w) ? word_fill : w;
      word_fill = 0;
      if (word_count == 0) begin
        open_line(wl);
      end else if (line_fill + 1 + wl <= w) begin
        gap_bits[line_fill] = 1'b1;
        line_buf[line_fill] = tfj_pkg::SpaceChar;
        for (int unsigned k = 0; k < wl; k++) line_buf[line_fill+1+k] = word_buf[k];
        line_fill += 1 + wl;
        word_count++;
      end else begin
        flush_line(1'b1, w);
        open_line(wl);
      end
      // last line of the text is left justified
      if (te) begin
        flush_line(1'b0, w);
        line_fill  = 0;
        word_count = 0;
        gap_bits   = '0;
      end
      if (pending.size() > mark) pending[pending.size()-1].run_last = 1'b1;
    endfunction

    // accepted output item
    function void match_char(just_char_t got);
      just_char_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%t unexpected output: char_out %0h line_end %0b run_last %0b",
                   $realtime, got.char_out, got.line_end, got.run_last);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        faults++;
        if (faults <= 10)
          $display("%t mismatch: char_out exp %0h got %0h, line_end exp %0b got %0b, %s%0b got %0b",
                   $realtime, want.char_out, got.char_out, want.line_end, got.line_end,
                   "run_last exp ", want.run_last, got.run_last);
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [tfj_pkg::CfgW-1:0]  cfg_line_width_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [tfj_pkg::CharW-1:0] char_in_i;
  logic                      word_end_i;
  logic                      text_end_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [tfj_pkg::CharW-1:0] char_out_o;
  logic                      line_end_o;
  logic                      run_last_o;

  line_justify_sb sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_req;

  text_full_justify_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_line_width_i (cfg_line_width_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .word_end_i       (word_end_i),
    .text_end_i       (text_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .char_out_o       (char_out_o),
    .line_end_o       (line_end_o),
    .run_last_o       (run_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: random stalls plus a long hold-off on request
  initial begin : recv_proc
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.match_char('{char_out: char_out_o, line_end: line_end_o, run_last: run_last_o});
  end

  // offer one item; entered and left at a falling edge
  task automatic send_item(logic [tfj_pkg::CharW-1:0] ch, logic we, logic te);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= ch;
    word_end_i <= we;
    text_end_i <= te;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_char(ch, we, te);
    @(negedge clk_i);
  endtask

  // let every owed character come out, then let a word placement finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_width(logic [tfj_pkg::CfgW-1:0] value);
    cfg_line_width_i <= value;
    cfg_we_i         <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_width(value);
  endtask

  function automatic logic [tfj_pkg::CharW-1:0] rand_char();
    return ($urandom_range(9) == 0) ? tfj_pkg::SpaceChar
                                    : tfj_pkg::CharW'($urandom_range(255));
  endfunction

  // mostly well-formed words, some overlong, some with random marks
  task automatic send_text(int unsigned budget);
    int unsigned sent, len, lmax, w, kind;
    bit te, we_last;
    sent = 0;
    while (sent < budget) begin
      w    = sb.eff_width();
      kind = $urandom_range(99);
      if (kind < 10) begin
        len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++)
          send_item(rand_char(), 1'($urandom_range(1)), $urandom_range(3) == 0);
      end else begin
        lmax = (w > 6 && $urandom_range(2) != 0) ? 6 : w;
        len  = (kind < 20) ? w + $urandom_range(1, 4) : $urandom_range(1, lmax);
        te      = ($urandom_range(6) == 0);
        we_last = !(te && $urandom_range(4) == 0);
        for (int unsigned k = 0; k < len; k++)
          send_item(rand_char(), (k == len - 1) && we_last, (k == len - 1) && te);
      end
      sent += len;
    end
  endtask

  // run limit
  initial begin
    #10ms;
    $display("text_full_justify_core_tb: FAIL");
    $finish;
  end

  // main sequence
  initial begin : main_proc
    logic [tfj_pkg::CfgW-1:0] widths[8];
    sb               = new();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req         = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_line_width_i <= '0;
    in_valid_i       <= 1'b0;
    char_in_i        <= '0;
    word_end_i       <= 1'b0;
    text_end_i       <= 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset width: top char, zero char with an inner space, then a full
    // justify with a leftover space, and a text end without a word end
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(tfj_pkg::SpaceChar, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    for (int k = 0; k < 5; k++) send_item(tfj_pkg::CharW'(8'h80 ^ k), k == 4, 1'b0);
    for (int k = 0; k < 11; k++) send_item(tfj_pkg::CharW'(8'h7F - k), k == 10, 1'b0);
    send_item(8'h01, 1'b0, 1'b1);
    settle();

    // narrow width: overlong word cut, single-word line, padded last line
    write_width(6'd3);
    for (int k = 0; k < 4; k++) send_item(tfj_pkg::CharW'(8'h61 + k), k == 3, 1'b0);
    send_item(8'h7A, 1'b1, 1'b1);
    settle();

    // random phases over width extremes and idle patterns
    widths = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd33, 6'($urandom_range(2, 31)), 6'd12};
    for (int p = 0; p < 8; p++) begin
      write_width(widths[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      // long output hold-off so the block backs up into its input
      if (p == 4) hold_req = 400;
      send_text(55);
      settle();
    end

    if (sb.faults == 0 && sb.pending.size() == 0) begin
      $display("text_full_justify_core_tb: PASS");
    end else begin
      $display("text_full_justify_core_tb: FAIL");
    end
    $finish;
  end

endmodule
